// ===== rtl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle strip packer package
// Shared widths, register map constants and result kind codes.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int unsigned VertexW  = 32;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register index, taken from the word address paddr[2].
  localparam logic [ApbAddrW-3:0] RegPadEveryStrip = '0;

  // Slots that must remain for one triangle after the degenerate vertices.
  localparam int unsigned DegMinRoom = 3;
  // Degenerate vertex counts for an even and an odd output strip fill.
  localparam int unsigned DupEven = 2;
  localparam int unsigned DupOdd  = 3;

  typedef logic [VertexW-1:0] vertex_t;

  typedef enum logic {
    KindVertex = 1'b0,
    KindClose  = 1'b1
  } kind_e;

endpackage

// ===== rtl/tsp_if.sv =====
// ----------------------------------------------------------------------------
// Triangle strip packer stream interfaces
// Valid/ready channels for source vertex items and packed result items.
// ----------------------------------------------------------------------------
interface tsp_in_if;
  import tsp_pkg::*;

  logic    valid;
  logic    ready;
  vertex_t vertex;
  logic    strip_end;
  logic    list_end;

  modport source (output valid, vertex, strip_end, list_end, input ready);
  modport sink   (input valid, vertex, strip_end, list_end, output ready);
endinterface

interface tsp_out_if;
  import tsp_pkg::*;

  logic    valid;
  logic    ready;
  vertex_t out_vertex;
  kind_e   kind;
  logic    last_of_run;

  modport source (output valid, out_vertex, kind, last_of_run, input ready);
  modport sink   (input valid, out_vertex, kind, last_of_run, output ready);
endinterface

// ===== rtl/tsp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Triangle strip packer configuration registers
// APB-style register file holding the pad_every_strip control bit.
// ----------------------------------------------------------------------------
module tsp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tsp_pkg::ApbDataW-1:0]  pwdata,
  output logic [tsp_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output logic                          pad_every_strip_o
);
  import tsp_pkg::*;

  logic pad_q;
  logic sel_pad;
  logic wr_en;

  assign sel_pad = (paddr[ApbAddrW-1:2] == RegPadEveryStrip);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    if (sel_pad) begin
      prdata[0] = pad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q <= 1'b1;
    end else if (wr_en && sel_pad) begin
      pad_q <= pwdata[0];
    end
  end

  assign pad_every_strip_o = pad_q;

endmodule

// ===== rtl/triangle_strip_packer_core.sv =====
// ----------------------------------------------------------------------------
// Triangle strip packer core
// Stitches variable-length source triangle strips into fixed-size output
// strips with degenerate vertices, restart vertices, padding and close markers.
// ----------------------------------------------------------------------------
// The block takes one source vertex item and emits the result items it causes
// through a single output register, one result per clock cycle while the
// output is ready. An item that causes one result is done once that result is
// emitted, so plain vertex streams run at one item per cycle when not stalled;
// an item that triggers stitching, a strip restart, padding or a close marker
// holds the input until all of its results are emitted. The next item is taken
// in the cycle that the last result of the current one moves into the output
// register, and that register refills while its previous result is being taken.
// An accepted item is held in the current-item register before its results enter
// the output register. pad_every_strip must only be written while no item is in flight.
module triangle_strip_packer_core #(
  parameter int unsigned STRIP_SIZE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tsp_in_if.sink                        in_i,
  tsp_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tsp_pkg::ApbDataW-1:0]  pwdata,
  output logic [tsp_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import tsp_pkg::*;

  localparam int unsigned FillW = $clog2(STRIP_SIZE + 1);
  localparam int unsigned NumPos = 12;
  localparam logic [FillW-1:0] FillFull = FillW'(STRIP_SIZE);

  // Result positions of one item, in emission order.
  typedef enum logic [3:0] {
    P_ST_PAD,
    P_ST_MARK,
    P_ST_DEG_LAST,
    P_ST_DEG_V,
    P_ST_DEG_V3,
    P_NS_MARK,
    P_NS_ODD,
    P_NS_TWO,
    P_NS_ONE,
    P_MAIN_V,
    P_END_PAD,
    P_END_MARK
  } pos_e;

  logic pad_every_strip;

  tsp_cfg_regs u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .pad_every_strip_o (pad_every_strip)
  );

  // Current item.
  logic    cur_valid_q;
  vertex_t cur_vertex_q;
  logic    cur_send_q;
  logic    cur_lend_q;

  // Packer state.
  logic [FillW-1:0] fill_q;
  vertex_t          last_em_q;
  vertex_t          prev1_q;
  vertex_t          prev2_q;
  logic             odd_q;
  logic             at_start_q;

  // Per-item sequencing.
  pos_e pos_q;
  logic first_q;
  logic pre_close_q;
  logic dup2_q;
  logic dup3_q;
  logic ns_close_q;

  // Output register.
  logic    out_valid_q;
  vertex_t out_vertex_q;
  kind_e   out_kind_q;
  logic    out_last_q;

  logic [FillW:0]    fill_ext;
  logic [FillW:0]    dup_amt;
  logic              fresh_dup2;
  logic              fresh_dup3;
  logic              fresh_pre_close;
  logic              fresh_ns_close;
  logic              pre_close;
  logic              dup2;
  logic              dup3;
  logic              ns_close;
  logic              full;
  logic [NumPos-1:0] applies;
  pos_e              eff;
  vertex_t           res_vertex;
  kind_e             res_kind;
  logic              res_last;
  logic              emit;
  logic              done;
  logic              in_ready;
  logic              load;
  logic              at_start_d;

  assign fill_ext   = {1'b0, fill_q};
  assign full       = (fill_q == FillFull);
  assign fresh_dup2 = (fill_q != '0);
  assign fresh_dup3 = fill_q[0];

  always_comb begin
    dup_amt = '0;
    if (fresh_dup3) begin
      dup_amt = (FillW + 1)'(DupOdd);
    end else if (fresh_dup2) begin
      dup_amt = (FillW + 1)'(DupEven);
    end
  end

  // The strip is closed first when fewer than DegMinRoom slots would remain.
  assign fresh_pre_close = (fill_ext + dup_amt + (FillW + 1)'(DegMinRoom))
                           > (FillW + 1)'(STRIP_SIZE);
  assign fresh_ns_close  = full;

  // Decisions are taken from the fill level the item finds on entry.
  assign pre_close = first_q ? fresh_pre_close : pre_close_q;
  assign dup2      = first_q ? fresh_dup2      : dup2_q;
  assign dup3      = first_q ? fresh_dup3      : dup3_q;
  assign ns_close  = first_q ? fresh_ns_close  : ns_close_q;

  always_comb begin
    applies                = '0;
    applies[P_ST_PAD]      = at_start_q & pre_close & pad_every_strip &
                             (fill_q != '0) & ~full;
    applies[P_ST_MARK]     = at_start_q & pre_close;
    applies[P_ST_DEG_LAST] = at_start_q & ~pre_close & dup2;
    applies[P_ST_DEG_V]    = at_start_q & ~pre_close & dup2;
    applies[P_ST_DEG_V3]   = at_start_q & ~pre_close & dup3;
    applies[P_NS_MARK]     = ~at_start_q & ns_close;
    applies[P_NS_ODD]      = ~at_start_q & ns_close & odd_q;
    applies[P_NS_TWO]      = ~at_start_q & ns_close;
    applies[P_NS_ONE]      = ~at_start_q & ns_close;
    applies[P_MAIN_V]      = 1'b1;
    applies[P_END_PAD]     = cur_lend_q & ~full;
    applies[P_END_MARK]    = cur_lend_q;
  end

  // First applicable position at or after the current one.
  always_comb begin
    eff = P_END_MARK;
    for (int i = int'(NumPos) - 1; i >= 0; i--) begin
      if ((4'(i) >= pos_q) && applies[i]) begin
        eff = pos_e'(4'(i));
      end
    end
  end

  always_comb begin
    res_vertex = cur_vertex_q;
    res_kind   = KindVertex;
    case (eff)
      P_ST_PAD, P_ST_DEG_LAST, P_END_PAD: res_vertex = last_em_q;
      P_ST_MARK, P_NS_MARK, P_END_MARK: begin
        res_vertex = '0;
        res_kind   = KindClose;
      end
      P_NS_ODD, P_NS_TWO: res_vertex = prev2_q;
      P_NS_ONE:           res_vertex = prev1_q;
      default:            res_vertex = cur_vertex_q;
    endcase
  end

  assign res_last = (eff == P_END_MARK) || ((eff == P_MAIN_V) && !cur_lend_q);

  assign emit     = cur_valid_q && (!out_valid_q || out_o.ready);
  assign done     = emit && res_last;
  assign in_ready = !cur_valid_q || done;
  assign load     = in_i.valid && in_ready;

  assign at_start_d = done ? 1'b0 : at_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      cur_vertex_q <= '0;
      cur_send_q   <= 1'b0;
      cur_lend_q   <= 1'b0;
      fill_q       <= '0;
      last_em_q    <= '0;
      prev1_q      <= '0;
      prev2_q      <= '0;
      odd_q        <= 1'b0;
      at_start_q   <= 1'b1;
      pos_q        <= P_ST_PAD;
      first_q      <= 1'b0;
      pre_close_q  <= 1'b0;
      dup2_q       <= 1'b0;
      dup3_q       <= 1'b0;
      ns_close_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_vertex_q <= '0;
      out_kind_q   <= KindVertex;
      out_last_q   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q  <= 1'b1;
        out_vertex_q <= res_vertex;
        out_kind_q   <= res_kind;
        out_last_q   <= res_last;
        pre_close_q  <= pre_close;
        dup2_q       <= dup2;
        dup3_q       <= dup3;
        ns_close_q   <= ns_close;
        if (res_kind == KindClose) begin
          fill_q <= '0;
        end else begin
          last_em_q <= res_vertex;
          if (!full) begin
            fill_q <= fill_q + FillW'(1);
          end
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (load) begin
        first_q <= 1'b1;
      end else if (emit) begin
        first_q <= 1'b0;
      end

      // A padding position repeats until the strip is full.
      if (load) begin
        // A finishing item may change at_start_q in this same cycle.
        if (done) begin
          pos_q <= (cur_lend_q || cur_send_q) ? P_ST_PAD : P_NS_MARK;
        end else begin
          pos_q <= at_start_d ? P_ST_PAD : P_NS_MARK;
        end
      end else if (emit && (eff != P_END_MARK)) begin
        pos_q <= ((eff == P_ST_PAD) || (eff == P_END_PAD)) ? eff
                                                            : pos_e'(eff + 4'd1);
      end

      if (load) begin
        cur_valid_q <= 1'b1;
      end else if (done) begin
        cur_valid_q <= 1'b0;
      end

      if (done) begin
        if (cur_lend_q) begin
          prev1_q    <= '0;
          prev2_q    <= '0;
          odd_q      <= 1'b0;
          at_start_q <= 1'b1;
        end else begin
          prev2_q    <= prev1_q;
          prev1_q    <= cur_vertex_q;
          odd_q      <= at_start_q ? 1'b1 : ~odd_q;
          at_start_q <= cur_send_q;
        end
      end

      if (load) begin
        cur_vertex_q <= in_i.vertex;
        cur_send_q   <= in_i.strip_end;
        cur_lend_q   <= in_i.list_end;
      end
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.out_vertex  = out_vertex_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.last_of_run = out_last_q;

endmodule
